// ===== src/gpps_pkg.sv =====
// shared types and constants for the goldbach prime pair search
`timescale 1ns / 1ps

package gpps_pkg;

  // width of the target and prime fields on the ports
  localparam int unsigned FieldBits = 16;

  // first candidate prime and first trial divisor
  localparam int unsigned FirstPrime = 2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_target;  // capture the accepted target
    logic init_p;       // candidate p back to two
    logic inc_p;        // next candidate p
    logic start_test;   // load number under test, divisor two, square four
    logic test_larger;  // on start_test: test target - p instead of p
    logic div_start;    // clear remainder, load dividend
    logic div_step;     // one restoring remainder step
    logic next_div;     // next trial divisor and its square
    logic load_result;  // capture the result beat
    logic found;        // on load_result: a pair was found
  } gpps_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic p_over;    // 2p exceeds target, search is over
    logic v_lt2;     // number under test is below two
    logic sq_gt_v;   // divisor squared exceeds number under test
    logic div_last;  // current remainder step is the last one
    logic rem_zero;  // remainder is zero
  } gpps_status_t;

endpackage

// ===== src/gpps_if.sv =====
// handshake channels for targets in and prime pairs out
`timescale 1ns / 1ps

interface gpps_target_if import gpps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FieldBits-1:0] target_value;

  modport source (output valid, output target_value, input ready);
  modport sink (input valid, input target_value, output ready);
endinterface

interface gpps_result_if import gpps_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 pair_found;
  logic [FieldBits-1:0] smaller_prime;
  logic [FieldBits-1:0] larger_prime;

  modport source (output valid, output pair_found, output smaller_prime,
                  output larger_prime, input ready);
  modport sink (input valid, input pair_found, input smaller_prime,
                input larger_prime, output ready);
endinterface

// ===== src/gpps_datapath.sv =====
// datapath: target, candidate, trial divisor, remainder unit and result registers
`timescale 1ns / 1ps

module gpps_datapath import gpps_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                 clk_i,
  input  gpps_cmd_t            cmd_i,
  input  logic [FieldBits-1:0] target_value_i,
  output gpps_status_t         status_o,
  output logic                 pair_found_o,
  output logic [FieldBits-1:0] smaller_prime_o,
  output logic [FieldBits-1:0] larger_prime_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  t_q, p_q, v_q, d_q, dvd_q;
  logic [W:0]    sq_q, r_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  q_w;
  logic [W:0]    r_shift;
  logic          r_ge;

  logic                 found_q;
  logic [FieldBits-1:0] small_q, large_q;

  assign q_w     = t_q - p_q;
  assign r_shift = {r_q[W-1:0], dvd_q[W-1]};
  assign r_ge    = (r_shift >= {1'b0, d_q});

  assign status_o.p_over   = ({p_q, 1'b0} > {1'b0, t_q});
  assign status_o.v_lt2    = (v_q < W'(FirstPrime));
  assign status_o.sq_gt_v  = (sq_q > {1'b0, v_q});
  assign status_o.div_last = (cnt_q == CW'(W - 1));
  assign status_o.rem_zero = (r_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_target) begin
      t_q <= W'(target_value_i);
    end
    if (cmd_i.init_p) begin
      p_q <= W'(FirstPrime);
    end else if (cmd_i.inc_p) begin
      p_q <= p_q + W'(1);
    end
    if (cmd_i.start_test) begin
      v_q  <= cmd_i.test_larger ? q_w : p_q;
      d_q  <= W'(FirstPrime);
      sq_q <= (W + 1)'(FirstPrime * FirstPrime);
    end else if (cmd_i.next_div) begin
      // (d+1)^2 = d^2 + 2d + 1
      d_q  <= d_q + W'(1);
      sq_q <= sq_q + {d_q, 1'b0} + (W + 1)'(1);
    end
    if (cmd_i.div_start) begin
      r_q   <= '0;
      dvd_q <= v_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      r_q   <= r_ge ? (r_shift - {1'b0, d_q}) : r_shift;
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.load_result) begin
      found_q <= cmd_i.found;
      small_q <= cmd_i.found ? FieldBits'(p_q) : '0;
      large_q <= cmd_i.found ? FieldBits'(q_w) : '0;
    end
  end

  assign pair_found_o    = found_q;
  assign smaller_prime_o = small_q;
  assign larger_prime_o  = large_q;

endmodule

// ===== src/gpps_ctrl.sv =====
// controller: search sequence, primality test steps and result handshake
`timescale 1ns / 1ps

module gpps_ctrl import gpps_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  gpps_status_t status_i,
  output gpps_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_TEST = 6'b000100,
    S_DIV  = 6'b001000,
    S_EVAL = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   larger_q, larger_d;
  logic   found_q, found_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    larger_d    = larger_q;
    found_d     = found_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.found = found_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_target = 1'b1;
          cmd_o.init_p      = 1'b1;
          state_d           = S_SCAN;
        end
      end
      S_SCAN: begin
        // also covers targets below four
        if (status_i.p_over) begin
          found_d = 1'b0;
          state_d = S_DONE;
        end else begin
          cmd_o.start_test = 1'b1;
          larger_d         = 1'b0;
          state_d          = S_TEST;
        end
      end
      S_TEST: begin
        priority if (status_i.v_lt2) begin
          cmd_o.inc_p = 1'b1;
          state_d     = S_SCAN;
        end else if (status_i.sq_gt_v) begin
          // no divisor left: prime
          if (larger_q) begin
            found_d = 1'b1;
            state_d = S_DONE;
          end else begin
            cmd_o.start_test  = 1'b1;
            cmd_o.test_larger = 1'b1;
            larger_d          = 1'b1;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.rem_zero) begin
          cmd_o.inc_p = 1'b1;
          state_d     = S_SCAN;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = S_TEST;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      larger_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      larger_q    <= larger_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/goldbach_prime_pair_search.sv =====
// top level of the goldbach prime pair search
//
//  channel   | dir | fields                                     | beats per item
//  ----------+-----+--------------------------------------------+---------------
//  target_i  | in  | target_value                               | 1
//  result_o  | out | pair_found, smaller_prime, larger_prime    | 1
//
// one target is searched at a time; the target port is ready only while idle
// each trial divisor passes the test, divide and evaluate states of the shared
// restoring remainder unit; a candidate p adds a scan, a test ending prime a test
// state, a pairless search a final scan; idle takes the target, done loads the result
// a result waits in the output register while the next target is searched; the
// next result load stalls until it is taken; reset clears the controller only
`timescale 1ns / 1ps

module goldbach_prime_pair_search import gpps_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gpps_target_if.sink   target_i,
  gpps_result_if.source result_o
);

  gpps_cmd_t    cmd;
  gpps_status_t status;

  gpps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (target_i.valid),
    .in_ready_o  (target_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gpps_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .target_value_i  (target_i.target_value),
    .status_o        (status),
    .pair_found_o    (result_o.pair_found),
    .smaller_prime_o (result_o.smaller_prime),
    .larger_prime_o  (result_o.larger_prime)
  );

endmodule

// ===== src/gpps_checker.sv =====
// port-level assertions for the goldbach prime pair search, bound to the top level
`timescale 1ns / 1ps

module gpps_checker import gpps_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic                 pair_found_i,
  input logic [FieldBits-1:0] smaller_prime_i,
  input logic [FieldBits-1:0] larger_prime_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pair_found_i) &&
      $stable(smaller_prime_i) && $stable(larger_prime_i))
    else $error("result beat changed while stalled");

  // one target in flight: no back to back accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("target accepted while a search is running");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !pair_found_i |-> smaller_prime_i == '0 && larger_prime_i == '0)
    else $error("no pair but nonzero primes");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pair_found_i |->
      smaller_prime_i >= FieldBits'(FirstPrime) && smaller_prime_i <= larger_prime_i)
    else $error("pair out of order or below two");

endmodule

bind goldbach_prime_pair_search gpps_checker u_gpps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (target_i.valid),
  .in_ready_i      (target_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .pair_found_i    (result_o.pair_found),
  .smaller_prime_i (result_o.smaller_prime),
  .larger_prime_i  (result_o.larger_prime)
);

// ===== tb/goldbach_prime_pair_search_test.sv =====
// testbench for the goldbach prime pair search: directed and random targets
`timescale 1ns / 1ps

module goldbach_prime_pair_search_test import gpps_pkg::*; ();

  localparam int unsigned WatchdogLimit = 1_000_000;
  localparam int unsigned DrainCycles   = 40;

  typedef struct {
    logic [FieldBits-1:0] target;
    logic                 found;
    logic [FieldBits-1:0] smaller;
    logic [FieldBits-1:0] larger;
  } prime_pair_t;

  logic clk_i;
  logic rst_ni;

  gpps_target_if target_bus ();
  gpps_result_if result_bus ();

  goldbach_prime_pair_search #(
    .VALUE_WIDTH(FieldBits)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .target_i(target_bus.sink),
    .result_o(result_bus.source)
  );

  prime_pair_t pending_pairs[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  bit          idle_en;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit prime_check(int unsigned v);
    int unsigned d;
    if (v < FirstPrime) return 1'b0;
    for (d = FirstPrime; d * d <= v; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // first p in ascending order with p and target - p both prime
  function automatic prime_pair_t goldbach_split(logic [FieldBits-1:0] target);
    prime_pair_t pair;
    int unsigned t;
    int unsigned p;
    t            = 32'(target);
    pair.target  = target;
    pair.found   = 1'b0;
    pair.smaller = '0;
    pair.larger  = '0;
    if (t >= 2 * FirstPrime) begin
      for (p = FirstPrime; p <= t - p; p++) begin
        if (prime_check(p) && prime_check(t - p)) begin
          pair.found   = 1'b1;
          pair.smaller = p[FieldBits-1:0];
          pair.larger  = FieldBits'(t - p);
          break;
        end
      end
    end
    return pair;
  endfunction

  // mostly short pauses, a few long ones
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report_mismatch(string field, logic [FieldBits-1:0] target,
                                 logic [FieldBits-1:0] want, logic [FieldBits-1:0] got);
    $display("mismatch on %s for target %0d: expected %0d, got %0d",
             field, target, want, got);
    mismatch_count++;
  endtask

  // one target beat; leaves valid high when no pause follows
  task automatic send_target(logic [FieldBits-1:0] target);
    int unsigned pause;
    prime_pair_t want_pair;
    target_bus.valid        <= 1'b1;
    target_bus.target_value <= target;
    do @(posedge clk_i); while (!target_bus.ready);
    want_pair     = goldbach_split(target);
    pending_pairs = {pending_pairs, want_pair};
    @(negedge clk_i);
    pause = pick_pause();
    if (pause > 0) begin
      target_bus.valid <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
  endtask

  task automatic run_corner_targets();
    logic [FieldBits-1:0] corners[] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 17, 27, 97, 128,
      16'h8000, 16'h5554, 16'hAAAA, 16'hFFFE, 65523
    };
    foreach (corners[i]) send_target(corners[i]);
  endtask

  task automatic run_even_targets(int unsigned count);
    repeat (count) send_target(FieldBits'(2 * $urandom_range(2, 32767)));
  endtask

  // odd targets across the whole range, picked so that target - 2 is prime
  task automatic run_odd_targets(int unsigned count);
    int unsigned t;
    repeat (count) begin
      do t = 2 * $urandom_range(2, 32767) + 1; while (!prime_check(t - 2));
      send_target(FieldBits'(t));
    end
  endtask

  // small targets, where odd ones without a pair run the whole search
  task automatic run_small_targets(int unsigned count);
    repeat (count) send_target(FieldBits'($urandom_range(0, 300)));
  endtask

  task automatic run_back_to_back(int unsigned count);
    idle_en = 1'b0;
    repeat (count) begin
      if ($urandom_range(0, 1)) send_target(FieldBits'(2 * $urandom_range(2, 32767)));
      else send_target(FieldBits'($urandom_range(0, 300)));
    end
    idle_en = 1'b1;
  endtask

  initial begin
    target_bus.valid        = 1'b0;
    target_bus.target_value = '0;
    result_bus.ready        = 1'b0;
    mismatch_count          = 0;
    idle_en                 = 1'b1;
    rst_ni                  = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_corner_targets();
    run_even_targets(25);
    run_odd_targets(15);
    run_small_targets(20);
    run_back_to_back(10);
    run_even_targets(10);

    target_bus.valid <= 1'b0;
    wait (pending_pairs.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int unsigned hold;
    int unsigned stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      hold = $urandom_range(1, 8);
      result_bus.ready <= 1'b1;
      repeat (hold) @(negedge clk_i);
      stall = pick_pause();
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    prime_pair_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (pending_pairs.size() == 0) begin
        report_mismatch("smaller_prime with no target pending", '0, '0,
                        result_bus.smaller_prime);
      end else begin
        want = pending_pairs.pop_front();
        if (result_bus.pair_found !== want.found)
          report_mismatch("pair_found", want.target, FieldBits'(want.found),
                          FieldBits'(result_bus.pair_found));
        if (result_bus.smaller_prime !== want.smaller)
          report_mismatch("smaller_prime", want.target, want.smaller, result_bus.smaller_prime);
        if (result_bus.larger_prime !== want.larger)
          report_mismatch("larger_prime", want.target, want.larger, result_bus.larger_prime);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((target_bus.valid && target_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
